// ----- rtl/crfe_pkg.sv -----
package crfe_pkg;

  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 200;
  localparam int STORE_DEPTH = SCREEN_W * SCREEN_H;

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W  = $clog2(SCREEN_W + 1);
  localparam int ROW_W  = $clog2(SCREEN_H + 1);
  localparam int CLIP_W = 14;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [11:0] left;
    logic signed [11:0] top;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [7:0]         fill_color;
    logic [15:0]        read_address;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_color;
    logic [15:0] pixels_written;
  } out_t;

  typedef struct packed {
    logic             kind;
    logic             blank;
    logic [7:0]       color;
    logic [COL_W-1:0] x0;
    logic [ROW_W-1:0] y0;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    logic [15:0]      read_address;
  } cmd_t;

endpackage

// ----- rtl/crfe_front.sv -----
module crfe_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  crfe_pkg::in_t   command,
  output logic            cmd_valid,
  input  logic            cmd_full,
  output crfe_pkg::cmd_t  cmd
);

  localparam logic signed [crfe_pkg::CLIP_W-1:0] W_S = crfe_pkg::CLIP_W'(crfe_pkg::SCREEN_W);
  localparam logic signed [crfe_pkg::CLIP_W-1:0] H_S = crfe_pkg::CLIP_W'(crfe_pkg::SCREEN_H);

  logic signed [crfe_pkg::CLIP_W-1:0] xs, ys, ws, hs, x1, y1, x0c, y0c, x1c, y1c, dx, dy;
  logic           off;
  logic           accept;
  crfe_pkg::cmd_t classified;

  always_comb begin
    xs  = crfe_pkg::CLIP_W'(command.left);
    ys  = crfe_pkg::CLIP_W'(command.top);
    ws  = $signed({2'b00, command.rect_width});
    hs  = $signed({2'b00, command.rect_height});
    x1  = xs + ws;
    y1  = ys + hs;
    x0c = (xs < 0) ? '0 : xs;
    y0c = (ys < 0) ? '0 : ys;
    x1c = (x1 > W_S) ? W_S : x1;
    y1c = (y1 > H_S) ? H_S : y1;
    dx  = x1c - x0c;
    dy  = y1c - y0c;
    off = (xs >= W_S) || (ys >= H_S) || (x1c <= x0c) || (y1c <= y0c);

    classified.kind         = command.kind;
    classified.blank        = off;
    classified.color        = command.fill_color;
    classified.x0           = x0c[crfe_pkg::COL_W-1:0];
    classified.y0           = y0c[crfe_pkg::ROW_W-1:0];
    classified.cols         = dx[crfe_pkg::COL_W-1:0];
    classified.rows         = dy[crfe_pkg::ROW_W-1:0];
    classified.read_address = command.read_address;
  end

  assign full   = cmd_valid && cmd_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_full) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= classified;
    end
  end

endmodule

// ----- rtl/crfe_queue.sv -----
module crfe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_full,
  input  crfe_pkg::cmd_t  wr_cmd,
  output logic            rd_valid,
  input  logic            rd_take,
  output crfe_pkg::cmd_t  rd_cmd
);

  crfe_pkg::cmd_t                entries [crfe_pkg::Q_DEPTH];
  logic [crfe_pkg::Q_PTR_W-1:0]  wptr, rptr;
  logic [crfe_pkg::Q_CNT_W-1:0]  count;
  logic                          do_wr, do_rd;

  assign wr_full  = (count == crfe_pkg::Q_CNT_W'(crfe_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && !wr_full;
  assign do_rd    = rd_take && rd_valid;
  assign rd_cmd   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_cmd;
    end
  end

endmodule

// ----- rtl/crfe_back.sv -----
module crfe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_take,
  input  crfe_pkg::cmd_t  cmd,
  output logic            empty,
  input  logic            pop,
  output crfe_pkg::out_t  result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t                      state;
  logic                        out_valid;
  logic [7:0]                  frame [crfe_pkg::STORE_DEPTH];
  logic [crfe_pkg::ADDR_W-1:0] addr, row_start, base, next_row, rd_idx;
  logic [crfe_pkg::COL_W-1:0]  col_left, cols;
  logic [crfe_pkg::ROW_W-1:0]  row_left;
  logic [7:0]                  color, rd_data;
  logic [15:0]                 count;
  logic                        rd_ok, rd_in_range, last_col, last_row, done;

  assign empty       = !out_valid;
  assign cmd_take    = cmd_valid && (state == S_IDLE) && (!out_valid || pop);
  assign base        = crfe_pkg::ADDR_W'(32'(cmd.y0) * 32'(crfe_pkg::SCREEN_W) + 32'(cmd.x0));
  assign next_row    = row_start + crfe_pkg::ADDR_W'(crfe_pkg::SCREEN_W);
  assign rd_idx      = crfe_pkg::ADDR_W'(cmd.read_address);
  assign rd_in_range = (32'(cmd.read_address) < 32'(crfe_pkg::STORE_DEPTH));
  assign last_col    = (col_left == crfe_pkg::COL_W'(1));
  assign last_row    = (row_left == crfe_pkg::ROW_W'(1));
  assign done        = (state == S_READ) || ((state == S_FILL) && last_col && last_row) ||
                       (cmd_take && (cmd.kind == crfe_pkg::KIND_FILL) && cmd.blank);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            if (cmd.kind == crfe_pkg::KIND_READ) begin
              state <= S_READ;
            end else if (!cmd.blank) begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (last_col && last_row) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          rd_data   <= frame[rd_idx];
          rd_ok     <= rd_in_range;
          addr      <= base;
          row_start <= base;
          cols      <= cmd.cols;
          col_left  <= cmd.cols;
          row_left  <= cmd.rows;
          color     <= cmd.color;
          count     <= '0;
          if (cmd.kind == crfe_pkg::KIND_FILL && cmd.blank) begin
            result <= '0;
          end
        end
      end
      S_FILL: begin
        frame[addr] <= color;
        count       <= count + 16'd1;
        if (last_col) begin
          addr      <= next_row;
          row_start <= next_row;
          col_left  <= cols;
          row_left  <= row_left - 1'b1;
          if (last_row) begin
            result.read_color     <= '0;
            result.pixels_written <= count + 16'd1;
          end
        end else begin
          addr     <= addr + 1'b1;
          col_left <= col_left - 1'b1;
        end
      end
      S_READ: begin
        result.read_color     <= rd_ok ? rd_data : 8'd0;
        result.pixels_written <= '0;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/clipped_rect_fill_engine.sv -----
// Clipped rectangle fill engine with its own 8-bit frame memory.
// Command side: drive command and raise push; the item is taken on a clock
// edge where push is high and full is low. kind selects a fill of a signed
// rectangle, clipped to the screen on every edge, or a read of one pixel
// at a linear address (row * screen width + column).
// Result side: while empty is low, result holds the oldest finished item;
// raise pop to take it. Each command gives exactly one result, in order.
// A taken command passes through the classify register and the command
// queue to the back end; a fill returns its clipped pixel count once its
// last pixel is written, and a fill clipped to nothing writes no pixels.
// The back end writes one pixel per cycle through the single frame memory
// port, runs one command at a time and takes no new read while one is in
// its read state. A classify register and a 4-entry command queue let new
// commands be taken while a fill is still writing.
// Reset clears the queue and the result valid flag; the frame memory keeps
// no reset value, so read only pixels that a fill has written.
// When the receiver holds off pop, the finished result waits in its
// register, the back end stalls, the queue fills and then full rises.
module clipped_rect_fill_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  crfe_pkg::in_t   command,
  output logic            empty,
  input  logic            pop,
  output crfe_pkg::out_t  result
);

  logic           f_valid, f_full, q_valid, q_take;
  crfe_pkg::cmd_t f_cmd, q_cmd;

  crfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .cmd_valid (f_valid),
    .cmd_full  (f_full),
    .cmd       (f_cmd)
  );

  crfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_full  (f_full),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_cmd   (q_cmd)
  );

  crfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_take  (q_take),
    .cmd       (q_cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

  localparam int STALL_LIMIT = 200000;
  localparam int TAIL_ITEMS  = 80;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 880;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  crfe_pkg::in_t  command = '0;
  crfe_pkg::out_t result;

  crfe_pkg::in_t  pending_cmds[$];
  crfe_pkg::out_t expected_results[$];
  logic [7:0] frame_model [crfe_pkg::STORE_DEPTH];

  int   error_count = 0;
  int   accepted_count = 0;
  int   stall_cycles = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   cmd_taken = 1'b0;
  int   last_left = 0;
  int   last_top = 0;
  int   last_width = 0;
  int   last_height = 0;

  clipped_rect_fill_engine DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .command(command),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    error_count++;
  endtask

  function automatic crfe_pkg::out_t predict_result(crfe_pkg::in_t cmd);
    crfe_pkg::out_t res;
    int   x0, y0, x1, y1;
    res = '0;
    if (cmd.kind == crfe_pkg::KIND_READ) begin
      if (cmd.read_address < crfe_pkg::STORE_DEPTH) begin
        res.read_color = frame_model[cmd.read_address];
      end
    end else begin
      x0 = int'($signed(cmd.left));
      y0 = int'($signed(cmd.top));
      if (x0 < crfe_pkg::SCREEN_W && y0 < crfe_pkg::SCREEN_H) begin
        x1 = x0 + int'(cmd.rect_width);
        y1 = y0 + int'(cmd.rect_height);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > crfe_pkg::SCREEN_W) x1 = crfe_pkg::SCREEN_W;
        if (y1 > crfe_pkg::SCREEN_H) y1 = crfe_pkg::SCREEN_H;
        if (x1 > x0 && y1 > y0) begin
          for (int row = y0; row < y1; row++) begin
            for (int col = x0; col < x1; col++) begin
              frame_model[row * crfe_pkg::SCREEN_W + col] = cmd.fill_color;
            end
          end
          res.pixels_written = 16'((x1 - x0) * (y1 - y0));
        end
      end
    end
    return res;
  endfunction

  task automatic add_fill(input int l, input int t, input int w, input int h, input int color);
    crfe_pkg::in_t cmd;
    logic [95:0]   noise;
    noise = {$urandom, $urandom, $urandom};
    cmd = noise[$bits(crfe_pkg::in_t)-1:0];
    cmd.kind        = crfe_pkg::KIND_FILL;
    cmd.left        = 12'(l);
    cmd.top         = 12'(t);
    cmd.rect_width  = 12'(w);
    cmd.rect_height = 12'(h);
    cmd.fill_color  = 8'(color);
    last_left   = l;
    last_top    = t;
    last_width  = w;
    last_height = h;
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_read(input int addr);
    crfe_pkg::in_t cmd;
    logic [95:0]   noise;
    noise = {$urandom, $urandom, $urandom};
    cmd = noise[$bits(crfe_pkg::in_t)-1:0];
    cmd.kind         = crfe_pkg::KIND_READ;
    cmd.read_address = 16'(addr);
    pending_cmds.push_back(cmd);
  endtask

  // Sender: hold an item until taken, then advance or idle.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || cmd_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (pending_cmds.size() > TAIL_ITEMS && hold_left == 0 &&
                   $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 12);
        push <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        command <= pending_cmds.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off to back the block up, random gaps elsewhere.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      pop <= 1'b0;
    end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    crfe_pkg::out_t want;
    cmd_taken <= !rst && push && !full;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result item %h", result));
        end else begin
          want = expected_results.pop_front();
          if (result.read_color !== want.read_color) begin
            report_mismatch($sformatf("read_color got %h, expected %h",
                                      result.read_color, want.read_color));
          end
          if (result.pixels_written !== want.pixels_written) begin
            report_mismatch($sformatf("pixels_written got %0d, expected %0d",
                                      result.pixels_written, want.pixels_written));
          end
        end
      end
      if (push && !full) begin
        expected_results.push_back(predict_result(command));
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int pick, x, y;

    // Clear the whole screen first so every later in-range read hits a written pixel.
    add_fill(0, 0, crfe_pkg::SCREEN_W, crfe_pkg::SCREEN_H, 8'h5A);
    add_read(0);
    add_read(crfe_pkg::STORE_DEPTH - 1);
    add_read(crfe_pkg::STORE_DEPTH);
    add_read(16'hFFFF);
    add_fill(0, 0, 1, 1, 8'hFF);
    add_read(0);
    add_fill(crfe_pkg::SCREEN_W - 1, crfe_pkg::SCREEN_H - 1, 1, 1, 8'h01);
    add_read(crfe_pkg::STORE_DEPTH - 1);
    add_fill(crfe_pkg::SCREEN_W, 0, 10, 10, 8'h11);
    add_fill(0, crfe_pkg::SCREEN_H, 10, 10, 8'h22);
    add_fill(2047, -2048, 4095, 4095, 8'h33);
    add_fill(-5, 10, 5, 4, 8'h44);
    add_fill(10, -3, 4, 3, 8'h55);
    add_fill(10, 10, 0, 5, 8'h66);
    add_fill(10, 10, 5, 0, 8'h77);
    add_fill(-10, 5, 20, 3, 8'h88);
    add_read(5 * crfe_pkg::SCREEN_W + 9);
    add_read(5 * crfe_pkg::SCREEN_W + 10);
    add_fill(100, 100, 4095, 1, 8'h99);
    add_read(100 * crfe_pkg::SCREEN_W + crfe_pkg::SCREEN_W - 1);
    add_fill(-2048, -2048, 4095, 4095, 8'hA5);
    add_read(12345);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        x = last_left + $urandom_range(0, last_width);
        y = last_top + $urandom_range(0, last_height);
        if (pick < 30 && x >= 0 && x < crfe_pkg::SCREEN_W &&
            y >= 0 && y < crfe_pkg::SCREEN_H) begin
          add_read(y * crfe_pkg::SCREEN_W + x);
        end else if (pick < 40) begin
          add_read($urandom_range(0, crfe_pkg::STORE_DEPTH - 1));
        end else begin
          add_read($urandom_range(crfe_pkg::STORE_DEPTH, 16'hFFFF));
        end
      end else if (pick < 47) begin
        add_fill($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                 $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255));
      end else begin
        add_fill($urandom_range(0, crfe_pkg::SCREEN_W + 40) - 30,
                 $urandom_range(0, crfe_pkg::SCREEN_H + 40) - 20,
                 $urandom_range(0, 40), $urandom_range(0, 24), $urandom_range(0, 255));
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || push) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
